[src/cba_pkg.sv]
// shared types and constants of the contiguous block allocator
// no dependencies; used by cba_cell and contiguous_block_allocator_unit
package cba_pkg;

  localparam int IDX_W = 5;
  localparam int LEN_W = 5;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    MAP_FREE  = 3'd0,
    MAP_ONE   = 3'd1,
    MAP_FIRST = 3'd2,
    MAP_MID   = 3'd3,
    MAP_LAST  = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [LEN_W-1:0]    size;
    logic [IDX_W-1:0]    block_index;
    logic                id_valid;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] first_block;
  } rsp_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic             capture;
    logic             alloc;
    logic             free_go;
    logic             head_one;
    logic             head_first;
    logic [IDX_W-1:0] idx;
    logic             commit_alloc;
    logic             commit_free;
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] len;
  } bcast_t;

endpackage

[src/cba_cell.sv]
// one block of the status map: holds its status and its fit and clear flags
// depends on cba_pkg
module cba_cell #(
  parameter int N   = 16,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cba_pkg::bcast_t  bc,
  input  logic [N-1:0]     lmask,
  input  logic [N-1:0]     gemask,
  input  logic [N-1:0]     win_up,
  output logic [N-1:0]     win_dn,
  input  logic [N-1:0]     last_in,
  output logic [N-1:0]     last_out,
  output cba_pkg::status_t status,
  output logic             fit
);

  cba_pkg::status_t status_r, status_nxt;
  logic fit_r, clr_r;
  logic fit_nxt, clr_nxt;
  logic [5:0] k6, s6, e6;
  logic in_run;
  logic is_free;

  assign is_free = (status_r == cba_pkg::MAP_FREE);

  // free window: this block and the ones above it, zero past the end
  assign win_dn = {win_up[N-2:0], is_free};

  always_comb begin
    last_out      = last_in;
    last_out[IDX] = (status_r == cba_pkg::MAP_LAST);
  end

  assign k6     = 6'(IDX);
  assign s6     = {1'b0, bc.start};
  assign e6     = s6 + {1'b0, bc.len};
  assign in_run = (k6 >= s6) && (k6 < e6);

  always_comb begin
    fit_nxt = bc.alloc && ((win_dn & lmask) == lmask);
    // clear from the head through the next last block below-to-above
    clr_nxt = bc.free_go &&
              ((bc.head_one && (k6 == {1'b0, bc.idx})) ||
               (bc.head_first && gemask[IDX] && ((last_in & gemask) == '0)));
  end

  always_comb begin
    status_nxt = status_r;
    if (bc.commit_alloc && in_run) begin
      if (bc.len == cba_pkg::LEN_W'(1)) begin
        status_nxt = cba_pkg::MAP_ONE;
      end else if (k6 == s6) begin
        status_nxt = cba_pkg::MAP_FIRST;
      end else if (k6 == e6 - 6'd1) begin
        status_nxt = cba_pkg::MAP_LAST;
      end else begin
        status_nxt = cba_pkg::MAP_MID;
      end
    end else if (bc.commit_free && clr_r) begin
      status_nxt = cba_pkg::MAP_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= cba_pkg::MAP_FREE;
    end else begin
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (bc.capture) begin
      fit_r <= fit_nxt;
      clr_r <= clr_nxt;
    end
  end

  assign status = status_r;
  assign fit    = fit_r;

endmodule

[src/contiguous_block_allocator_unit.sv]
// first-fit contiguous block allocator built as a row of block cells
// depends on cba_pkg and cba_cell
//
// channel   ports                     handshake
// request   start, busy, in_data      taken at an edge with start high and busy low
// result    out_valid, out_data       one cycle, marked by out_valid, no back pressure
//
// for each word, in the accept cycle each cell checks whether a
// run of the requested size starts at it (or whether it is cleared by a free)
// and latches that flag; in the commit cycle a priority encoder over the cell
// flags picks the lowest start and the cells rewrite their status
// the result word shows in the cycle after the commit, while the next word can
// already be accepted; reset is synchronous and leaves every block free
module contiguous_block_allocator_unit #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  cba_pkg::req_t in_data,
  output logic          out_valid,
  output cba_pkg::rsp_t out_data
);

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  cba_pkg::state_t state_r, state_nxt;
  logic accept;

  // request fields kept for the commit cycle
  logic                     alloc_r;
  logic [cba_pkg::LEN_W-1:0] len_r;
  logic                     len_zero_r, len_ok_r, free_ok_r;

  logic          out_valid_r, out_valid_nxt;
  cba_pkg::rsp_t out_data_r, out_data_nxt;

  // cell chains
  logic [NUM_BLOCKS-1:0] win_w  [NUM_BLOCKS+1];
  logic [NUM_BLOCKS-1:0] last_w [NUM_BLOCKS+1];
  cba_pkg::status_t      status_w [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] fit_vec;
  logic [NUM_BLOCKS-1:0] lmask, gemask;

  cba_pkg::bcast_t bc;
  logic in_range, len_ok, is_alloc;
  cba_pkg::status_t head;
  logic any_fit, alloc_ok;
  logic [cba_pkg::IDX_W-1:0] sel;

  assign busy   = (state_r == cba_pkg::ST_COMMIT);
  assign accept = start && !busy;

  assign is_alloc = (in_data.action == cba_pkg::ACT_ALLOC);
  assign in_range = ({1'b0, in_data.block_index} < 6'(NUM_BLOCKS));
  assign len_ok   = ({1'b0, in_data.size} <= 6'(NUM_BLOCKS));
  assign head     = in_range ? status_w[in_data.block_index[IW-1:0]] : cba_pkg::MAP_FREE;

  // run length mask and "at or above the freed index" mask
  always_comb begin
    for (int j = 0; j < NUM_BLOCKS; j++) begin
      lmask[j]  = (6'(j) <  {1'b0, in_data.size});
      gemask[j] = (6'(j) >= {1'b0, in_data.block_index});
    end
  end

  // lowest cell that can hold the run
  always_comb begin
    sel = '0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (fit_vec[i]) sel = cba_pkg::IDX_W'(i);
    end
  end

  assign any_fit  = |fit_vec;
  assign alloc_ok = len_zero_r || (len_ok_r && any_fit);

  always_comb begin
    bc              = '0;
    bc.capture      = accept;
    bc.alloc        = is_alloc;
    bc.free_go      = !is_alloc && in_data.id_valid && in_range;
    bc.head_one     = (head == cba_pkg::MAP_ONE);
    bc.head_first   = (head == cba_pkg::MAP_FIRST);
    bc.idx          = in_data.block_index;
    bc.commit_alloc = busy && alloc_r && !len_zero_r && len_ok_r && any_fit;
    bc.commit_free  = busy && !alloc_r;
    bc.start        = sel;
    bc.len          = len_r;
  end

  assign win_w[NUM_BLOCKS] = '0;
  assign last_w[0]         = '0;

  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    cba_cell #(
      .N   (NUM_BLOCKS),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bc       (bc),
      .lmask    (lmask),
      .gemask   (gemask),
      .win_up   (win_w[i+1]),
      .win_dn   (win_w[i]),
      .last_in  (last_w[i]),
      .last_out (last_w[i+1]),
      .status   (status_w[i]),
      .fit      (fit_vec[i])
    );
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      alloc_r    <= is_alloc;
      len_r      <= in_data.size;
      len_zero_r <= (in_data.size == '0);
      len_ok_r   <= len_ok;
      free_ok_r  <= bc.free_go && (bc.head_one || bc.head_first);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      cba_pkg::ST_IDLE: begin
        if (start) state_nxt = cba_pkg::ST_COMMIT;
      end
      cba_pkg::ST_COMMIT: begin
        state_nxt     = cba_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        out_data_nxt.ok = alloc_r ? alloc_ok : free_ok_r;
        out_data_nxt.first_block =
          (alloc_r && !len_zero_r && alloc_ok) ? sel : '0;
      end
      default: state_nxt = cba_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cba_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
